>>> rtl/core/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and codes of the token lexer and classifier.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int unsigned DEPTH_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_AW       = $clog2(QUEUE_DEPTH);
  localparam int unsigned MAX_RES        = 3;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // token classes
  localparam logic [2:0] CLS_SPECIAL = 3'd0;
  localparam logic [2:0] CLS_QUOTED  = 3'd1;
  localparam logic [2:0] CLS_DEC     = 3'd2;
  localparam logic [2:0] CLS_HEX     = 3'd3;
  localparam logic [2:0] CLS_FLOAT   = 3'd4;
  localparam logic [2:0] CLS_WORD    = 3'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] data;
    logic [2:0] cls;
  } result_t;

  // all results caused by one input word
  typedef struct packed {
    logic [1:0]                cnt;
    result_t [MAX_RES-1:0]     res;
  } bundle_t;

endpackage

>>> rtl/core/tlc_front.sv
// ----------------------------------------------------------------------------
// tlc_front
// Lexer state and classification: turns one accepted input word into a
// bundle of zero to three results.
// ----------------------------------------------------------------------------
module tlc_front #(
  parameter int unsigned DEPTH_BITS = tlc_pkg::DEPTH_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             at_end_i,
  output tlc_pkg::bundle_t bundle_o
);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_QUOTE   = 3'd2,
    MODE_EQ      = 3'd3,
    MODE_WORD    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    SH_START    = 3'd0,
    SH_MINUS    = 3'd1,
    SH_MANT     = 3'd2,
    SH_FRAC     = 3'd3,
    SH_EXP      = 3'd4,
    SH_EXPMINUS = 3'd5,
    SH_EXPDIG   = 3'd6,
    SH_FAIL     = 3'd7
  } shape_e;

  typedef enum logic [2:0] {
    HEX_NONE = 3'd0,
    HEX_ZERO = 3'd1,
    HEX_X    = 3'd2,
    HEX_DIG  = 3'd3,
    HEX_DEAD = 3'd4
  } hex_e;

  typedef struct packed {
    shape_e shape;
    logic   digit_seen;
    logic   int_ok;
    logic   hex_ok;
    logic   float_ok;
    hex_e   hex_phase;
  } word_t;

  localparam logic [6:0] CH_PCT   = 7'h25;
  localparam logic [6:0] CH_BTICK = 7'h60;
  localparam logic [6:0] CH_APOS  = 7'h27;
  localparam logic [6:0] CH_EQ    = 7'h3D;
  localparam logic [6:0] CH_BANG  = 7'h21;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_E_UP  = 7'h45;
  localparam logic [6:0] CH_E_LO  = 7'h65;
  localparam logic [6:0] CH_X_UP  = 7'h58;
  localparam logic [6:0] CH_X_LO  = 7'h78;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;
  localparam logic [6:0] CH_LF    = 7'h0A;

  localparam word_t WORD_START = '{shape: SH_START, digit_seen: 1'b0, int_ok: 1'b1,
                                   hex_ok: 1'b0, float_ok: 1'b0, hex_phase: HEX_NONE};

  function automatic logic is_space(logic [6:0] c);
    return (c == 7'h20) || (c >= 7'h09 && c <= 7'h0D);
  endfunction

  function automatic logic is_special(logic [6:0] c);
    return (c == 7'h22) || (c == CH_BTICK) || (c == 7'h2C) || (c == 7'h28) ||
           (c == 7'h29) || (c == 7'h5B) || (c == 7'h5D) || (c == 7'h7B) ||
           (c == 7'h7D) || (c == CH_EQ) || (c == 7'h40);
  endfunction

  function automatic logic is_digit(logic [6:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_xdigit(logic [6:0] c);
    return is_digit(c) || (c >= 7'h61 && c <= 7'h66) || (c >= 7'h41 && c <= 7'h46);
  endfunction

  function automatic word_t word_feed(word_t w, logic [6:0] c);
    word_t r;
    logic  first;
    logic  dig;
    logic  e;
    r     = w;
    first = (w.shape == SH_START);
    dig   = is_digit(c);
    e     = (c == CH_E_UP) || (c == CH_E_LO);

    // a leading minus leaves the integer flags alone
    if (!(first && c == CH_MINUS)) begin
      if (dig) begin
        r.digit_seen = 1'b1;
      end else begin
        r.int_ok = 1'b0;
      end
    end

    unique case (w.hex_phase)
      HEX_NONE: r.hex_phase = (c == CH_ZERO) ? HEX_ZERO : HEX_DEAD;
      HEX_ZERO: r.hex_phase = (c == CH_X_UP || c == CH_X_LO) ? HEX_X : HEX_DEAD;
      HEX_X, HEX_DIG: r.hex_phase = is_xdigit(c) ? HEX_DIG : HEX_DEAD;
      default: r.hex_phase = w.hex_phase;
    endcase
    r.hex_ok = (r.hex_phase == HEX_DIG);

    unique case (w.shape)
      SH_START, SH_MINUS, SH_MANT: begin
        if (w.shape == SH_START && c == CH_MINUS) r.shape = SH_MINUS;
        else if (dig)                             r.shape = SH_MANT;
        else if (c == CH_DOT)                     r.shape = SH_FRAC;
        else if (e)                               r.shape = SH_EXP;
        else                                      r.shape = SH_FAIL;
      end
      SH_FRAC:  r.shape = dig ? SH_FRAC : (e ? SH_EXP : SH_FAIL);
      SH_EXP:   r.shape = (c == CH_MINUS) ? SH_EXPMINUS : (dig ? SH_EXPDIG : SH_FAIL);
      SH_EXPMINUS, SH_EXPDIG: r.shape = dig ? SH_EXPDIG : SH_FAIL;
      default:  r.shape = SH_FAIL;
    endcase
    r.float_ok = (r.shape == SH_MANT) || (r.shape == SH_FRAC) || (r.shape == SH_EXPDIG);
    return r;
  endfunction

  function automatic logic [2:0] word_class(word_t w);
    if (w.hex_ok) return tlc_pkg::CLS_HEX;
    if (w.int_ok && w.digit_seen) return tlc_pkg::CLS_DEC;
    if (w.float_ok) return tlc_pkg::CLS_FLOAT;
    return tlc_pkg::CLS_WORD;
  endfunction

  mode_e                 mode_q, mode_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  word_t                 word_q, word_d;

  logic                  is_end;
  logic [6:0]            c;
  logic                  do_idle;
  logic [1:0]            n;
  tlc_pkg::result_t [tlc_pkg::MAX_RES-1:0] res;

  assign is_end = at_end_i || in_byte_i[7];
  assign c      = in_byte_i[6:0];

  always_comb begin
    mode_d  = mode_q;
    depth_d = depth_q;
    word_d  = word_q;
    do_idle = 1'b0;
    n       = '0;
    res     = '0;

    unique case (mode_q)
      MODE_COMMENT: begin
        if (is_end) begin
          res[n] = '{kind: tlc_pkg::KIND_DONE, data: 7'd0, cls: 3'd0};
          n      = n + 2'd1;
          mode_d = MODE_IDLE;
        end else if (c == CH_LF) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_QUOTE: begin
        if (is_end) begin
          res[n]  = '{kind: tlc_pkg::KIND_ERROR, data: 7'd0, cls: 3'd0};
          n       = n + 2'd1;
          depth_d = '0;
          mode_d  = MODE_IDLE;
        end else begin
          // depth saturates on open, wraps on close
          if (c == CH_BTICK && depth_q != '1) depth_d = depth_q + 1'b1;
          if (c == CH_APOS) depth_d = depth_q - 1'b1;
          res[n] = '{kind: tlc_pkg::KIND_BYTE, data: c, cls: 3'd0};
          n      = n + 2'd1;
          if (c == CH_APOS && depth_d == '0) begin
            res[n] = '{kind: tlc_pkg::KIND_END, data: 7'd0, cls: tlc_pkg::CLS_QUOTED};
            n      = n + 2'd1;
            mode_d = MODE_IDLE;
          end
        end
      end
      MODE_EQ: begin
        if (is_end) begin
          res[n] = '{kind: tlc_pkg::KIND_END, data: 7'd0, cls: tlc_pkg::CLS_SPECIAL};
          n      = n + 2'd1;
          res[n] = '{kind: tlc_pkg::KIND_DONE, data: 7'd0, cls: 3'd0};
          n      = n + 2'd1;
          mode_d = MODE_IDLE;
        end else if (c == CH_BANG) begin
          res[n] = '{kind: tlc_pkg::KIND_BYTE, data: c, cls: 3'd0};
          n      = n + 2'd1;
          res[n] = '{kind: tlc_pkg::KIND_END, data: 7'd0, cls: tlc_pkg::CLS_SPECIAL};
          n      = n + 2'd1;
          mode_d = MODE_IDLE;
        end else begin
          res[n]  = '{kind: tlc_pkg::KIND_END, data: 7'd0, cls: tlc_pkg::CLS_SPECIAL};
          n       = n + 2'd1;
          do_idle = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_end) begin
          res[n] = '{kind: tlc_pkg::KIND_END, data: 7'd0, cls: word_class(word_q)};
          n      = n + 2'd1;
          res[n] = '{kind: tlc_pkg::KIND_DONE, data: 7'd0, cls: 3'd0};
          n      = n + 2'd1;
          mode_d = MODE_IDLE;
        end else if (is_space(c)) begin
          res[n] = '{kind: tlc_pkg::KIND_END, data: 7'd0, cls: word_class(word_q)};
          n      = n + 2'd1;
          mode_d = MODE_IDLE;
        end else if (is_special(c)) begin
          res[n]  = '{kind: tlc_pkg::KIND_END, data: 7'd0, cls: word_class(word_q)};
          n       = n + 2'd1;
          do_idle = 1'b1;
        end else begin
          word_d = word_feed(word_q, c);
          res[n] = '{kind: tlc_pkg::KIND_BYTE, data: c, cls: 3'd0};
          n      = n + 2'd1;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        if (is_end) begin
          res[n] = '{kind: tlc_pkg::KIND_DONE, data: 7'd0, cls: 3'd0};
          n      = n + 2'd1;
        end else begin
          do_idle = 1'b1;
        end
      end
    endcase

    // byte handled as at the start of a token
    if (do_idle) begin
      mode_d = MODE_IDLE;
      if (is_space(c)) begin
        mode_d = MODE_IDLE;
      end else if (c == CH_PCT) begin
        mode_d = MODE_COMMENT;
      end else if (c == CH_BTICK) begin
        res[n]  = '{kind: tlc_pkg::KIND_BYTE, data: c, cls: 3'd0};
        n       = n + 2'd1;
        depth_d = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
        mode_d  = MODE_QUOTE;
      end else if (c == CH_EQ) begin
        res[n] = '{kind: tlc_pkg::KIND_BYTE, data: c, cls: 3'd0};
        n      = n + 2'd1;
        mode_d = MODE_EQ;
      end else if (is_special(c)) begin
        res[n] = '{kind: tlc_pkg::KIND_BYTE, data: c, cls: 3'd0};
        n      = n + 2'd1;
        res[n] = '{kind: tlc_pkg::KIND_END, data: 7'd0, cls: tlc_pkg::CLS_SPECIAL};
        n      = n + 2'd1;
      end else begin
        word_d = word_feed(WORD_START, c);
        res[n] = '{kind: tlc_pkg::KIND_BYTE, data: c, cls: 3'd0};
        n      = n + 2'd1;
        mode_d = MODE_WORD;
      end
    end
  end

  assign bundle_o.cnt = n;
  assign bundle_o.res = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      depth_q <= '0;
      word_q  <= WORD_START;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      word_q  <= word_d;
    end
  end

endmodule

>>> rtl/core/tlc_queue.sv
// ----------------------------------------------------------------------------
// tlc_queue
// Short queue of result bundles between the lexer and the output side.
// ----------------------------------------------------------------------------
module tlc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  tlc_pkg::bundle_t wr_data_i,
  input  logic             rd_i,
  output tlc_pkg::bundle_t rd_data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned AW = tlc_pkg::QUEUE_AW;
  localparam int unsigned CW = $clog2(tlc_pkg::QUEUE_DEPTH + 1);

  tlc_pkg::bundle_t mem_q [tlc_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_wr, do_rd;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == CW'(tlc_pkg::QUEUE_DEPTH));
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= AW'(wr_ptr_q + 1'b1);
      if (do_rd) rd_ptr_q <= AW'(rd_ptr_q + 1'b1);
      unique case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/core/tlc_back.sv
// ----------------------------------------------------------------------------
// tlc_back
// Output side: walks the results of the oldest bundle one per pop.
// ----------------------------------------------------------------------------
module tlc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlc_pkg::bundle_t head_i,
  input  logic             head_valid_i,
  output logic             head_done_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [1:0]       kind_o,
  output logic [6:0]       out_byte_o,
  output logic [2:0]       token_class_o,
  output logic             last_of_step_o
);

  logic [1:0]        idx_q;
  tlc_pkg::result_t  cur;
  logic              is_last;
  logic              take;

  assign cur            = head_i.res[idx_q];
  assign is_last        = (idx_q == head_i.cnt - 2'd1);
  assign empty_o        = !head_valid_i;
  assign take           = pop_i && head_valid_i;
  assign head_done_o    = take && is_last;
  assign kind_o         = cur.kind;
  assign out_byte_o     = cur.data;
  assign token_class_o  = cur.cls;
  assign last_of_step_o = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

>>> rtl/core/token_lexer_classifier_unit.sv
// ----------------------------------------------------------------------------
// token_lexer_classifier_unit
// Byte-stream lexer that emits token bytes and classed token ends.
// ----------------------------------------------------------------------------
// Input side is a queue write port: drive in_byte_i/at_end_i with push; a
// word is taken on a clock edge with push high and full low. Output side is
// a queue read port: while empty is low the oldest result sits on kind_o,
// out_byte_o, token_class_o and last_of_step_o, and pop takes it.
// Each input word is classified in the cycle it is taken; its results (zero
// to three) go into a four-entry bundle queue and, when the queue is empty,
// show at the output from the next cycle.
// Throughput: one input word per cycle while full is low; the output drains
// one result per cycle while pop is high, so words with two or three results
// hold the input side once the bundle queue fills. Words with no result
// (whitespace, comment bytes) never use the queue, but also wait on full.
// Reset clears the lexer to idle between tokens and empties the queue.
// When the receiver stops popping, results wait in the queue and full rises
// after four pending bundles; the lexer state holds until push is taken.
// ----------------------------------------------------------------------------
module token_lexer_classifier_unit #(
  parameter int unsigned DEPTH_BITS = tlc_pkg::DEPTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       at_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [6:0] out_byte_o,
  output logic [2:0] token_class_o,
  output logic       last_of_step_o
);

  tlc_pkg::bundle_t bundle;
  tlc_pkg::bundle_t head;
  logic             accept;
  logic             q_empty;
  logic             q_full;
  logic             head_done;

  assign full   = q_full;
  assign accept = push && !q_full;

  tlc_front #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .at_end_i  (at_end_i),
    .bundle_o  (bundle)
  );

  // bundles with no result are dropped here
  tlc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept && (bundle.cnt != 2'd0)),
    .wr_data_i (bundle),
    .rd_i      (head_done),
    .rd_data_o (head),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  tlc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_valid_i   (!q_empty),
    .head_done_o    (head_done),
    .empty_o        (empty),
    .pop_i          (pop),
    .kind_o         (kind_o),
    .out_byte_o     (out_byte_o),
    .token_class_o  (token_class_o),
    .last_of_step_o (last_of_step_o)
  );

endmodule

>>> bench/tb_token_lexer_classifier_unit.sv
// ----------------------------------------------------------------------------
// tb_token_lexer_classifier_unit
// Self-checking bench for the token lexer: a cycle-free model of the lexer
// predicts the results of every byte word taken, and a receiver process pops
// results with random stalls and compares them field by field in order.
// ----------------------------------------------------------------------------
module tb_token_lexer_classifier_unit;

  localparam int unsigned DEPTH_BITS = tlc_pkg::DEPTH_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned RANDOM_WORDS = 420;
  localparam int unsigned QUOTE_NEST = 12;
  localparam int unsigned PRINT_CAP = 40;

  // character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_BQUOTE  = 8'h60;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_HIGH    = 8'hFF;

  // number shape codes
  localparam logic [2:0] SH_START    = 3'd0;
  localparam logic [2:0] SH_MINUS    = 3'd1;
  localparam logic [2:0] SH_MANT     = 3'd2;
  localparam logic [2:0] SH_FRAC     = 3'd3;
  localparam logic [2:0] SH_EXP      = 3'd4;
  localparam logic [2:0] SH_EXPMINUS = 3'd5;
  localparam logic [2:0] SH_EXPDIG   = 3'd6;
  localparam logic [2:0] SH_FAIL     = 3'd7;

  // progress through the 0x prefix
  localparam logic [2:0] HX_NONE   = 3'd0;
  localparam logic [2:0] HX_ZERO   = 3'd1;
  localparam logic [2:0] HX_X      = 3'd2;
  localparam logic [2:0] HX_DIGITS = 3'd3;
  localparam logic [2:0] HX_DEAD   = 3'd4;

  typedef enum logic [2:0] {
    LX_IDLE, LX_COMMENT, LX_QUOTE, LX_EQ, LX_WORD
  } lex_mode_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] data;
    logic [2:0] cls;
    logic       last;
  } tok_res_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte_i = 8'h00;
  logic       at_end_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] kind_o;
  logic [6:0] out_byte_o;
  logic [2:0] token_class_o;
  logic       last_of_step_o;

  token_lexer_classifier_unit #(
    .DEPTH_BITS(DEPTH_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_byte_i     (in_byte_i),
    .at_end_i      (at_end_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .token_class_o (token_class_o),
    .last_of_step_o(last_of_step_o)
  );

  always #1 clk_i = ~clk_i;

  // lexer state as predicted
  lex_mode_e             lx_mode = LX_IDLE;
  logic [DEPTH_BITS-1:0] lx_depth = '0;
  logic [2:0]            lx_shape = SH_START;
  logic                  lx_digit = 1'b0;
  logic                  lx_int_ok = 1'b1;
  logic                  lx_hex_ok = 1'b0;
  logic                  lx_float_ok = 1'b0;
  logic [2:0]            lx_hex = HX_NONE;

  tok_res_t step_res[$];
  tok_res_t due_results[$];

  int unsigned send_gap_max = 0;
  int unsigned recv_gap_max = 0;
  int unsigned recv_hold = 0;
  bit          push_up = 1'b0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned full_stalls = 0;
  int unsigned error_count = 0;
  int unsigned cycles = 0;
  int unsigned class_seen[6] = '{default: 0};

  logic [7:0] specials[11] = '{CH_DQUOTE, CH_BQUOTE, CH_COMMA, CH_LPAREN, CH_RPAREN,
                               CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_EQ, CH_AT};

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_special(logic [7:0] c);
    foreach (specials[i]) if (specials[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_xdigit(logic [7:0] c);
    return is_digit(c) || (c >= CH_LOWER_A && c <= CH_LOWER_F) ||
           (c >= CH_UPPER_A && c <= CH_UPPER_F);
  endfunction

  function automatic void add_res(logic [1:0] k, logic [7:0] c, logic [2:0] cls);
    tok_res_t r;
    r.kind = k;
    r.data = c[6:0];
    r.cls  = cls;
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void word_begin();
    lx_shape    = SH_START;
    lx_digit    = 1'b0;
    lx_int_ok   = 1'b1;
    lx_hex_ok   = 1'b0;
    lx_float_ok = 1'b0;
    lx_hex      = HX_NONE;
  endfunction

  function automatic void word_take(logic [7:0] c);
    bit         first;
    bit         dig;
    bit         is_e;
    logic [2:0] s;
    first = (lx_shape == SH_START);
    dig   = is_digit(c);
    is_e  = (c == CH_UPPER_E || c == CH_LOWER_E);
    s     = lx_shape;
    // a leading minus keeps the word a candidate integer
    if (!(first && c == CH_MINUS)) begin
      if (dig) lx_digit = 1'b1;
      else lx_int_ok = 1'b0;
    end
    case (lx_hex)
      HX_NONE: lx_hex = (c == CH_ZERO) ? HX_ZERO : HX_DEAD;
      HX_ZERO: lx_hex = (c == CH_UPPER_X || c == CH_LOWER_X) ? HX_X : HX_DEAD;
      HX_X, HX_DIGITS: lx_hex = is_xdigit(c) ? HX_DIGITS : HX_DEAD;
      default: ;
    endcase
    lx_hex_ok = (lx_hex == HX_DIGITS);
    case (s)
      SH_START, SH_MINUS, SH_MANT: begin
        if (s == SH_START && c == CH_MINUS) s = SH_MINUS;
        else if (dig) s = SH_MANT;
        else if (c == CH_DOT) s = SH_FRAC;
        else if (is_e) s = SH_EXP;
        else s = SH_FAIL;
      end
      SH_FRAC: s = dig ? SH_FRAC : (is_e ? SH_EXP : SH_FAIL);
      SH_EXP: s = (c == CH_MINUS) ? SH_EXPMINUS : (dig ? SH_EXPDIG : SH_FAIL);
      SH_EXPMINUS, SH_EXPDIG: s = dig ? SH_EXPDIG : SH_FAIL;
      default: s = SH_FAIL;
    endcase
    lx_shape    = s;
    lx_float_ok = (s == SH_MANT || s == SH_FRAC || s == SH_EXPDIG);
  endfunction

  function automatic logic [2:0] word_cls();
    if (lx_hex_ok) return tlc_pkg::CLS_HEX;
    if (lx_int_ok && lx_digit) return tlc_pkg::CLS_DEC;
    if (lx_float_ok) return tlc_pkg::CLS_FLOAT;
    return tlc_pkg::CLS_WORD;
  endfunction

  function automatic void idle_take(logic [7:0] c);
    lx_mode = LX_IDLE;
    if (is_space(c)) return;
    if (c == CH_PERCENT) begin
      lx_mode = LX_COMMENT;
    end else if (c == CH_BQUOTE) begin
      add_res(tlc_pkg::KIND_BYTE, c, tlc_pkg::CLS_SPECIAL);
      lx_depth = DEPTH_BITS'(1);
      lx_mode = LX_QUOTE;
    end else if (c == CH_EQ) begin
      add_res(tlc_pkg::KIND_BYTE, c, tlc_pkg::CLS_SPECIAL);
      lx_mode = LX_EQ;
    end else if (is_special(c)) begin
      add_res(tlc_pkg::KIND_BYTE, c, tlc_pkg::CLS_SPECIAL);
      add_res(tlc_pkg::KIND_END, CH_NUL, tlc_pkg::CLS_SPECIAL);
    end else begin
      word_begin();
      word_take(c);
      add_res(tlc_pkg::KIND_BYTE, c, tlc_pkg::CLS_SPECIAL);
      lx_mode = LX_WORD;
    end
  endfunction

  // advance the lexer by one word and queue the results it should give
  function automatic void lex_predict(logic [7:0] c, logic end_in);
    bit fin;
    fin = end_in || c[7];
    step_res.delete();
    case (lx_mode)
      LX_COMMENT: begin
        if (fin) begin
          add_res(tlc_pkg::KIND_DONE, CH_NUL, tlc_pkg::CLS_SPECIAL);
          lx_mode = LX_IDLE;
        end else if (c == CH_LF) begin
          lx_mode = LX_IDLE;
        end
      end
      LX_QUOTE: begin
        if (fin) begin
          add_res(tlc_pkg::KIND_ERROR, CH_NUL, tlc_pkg::CLS_SPECIAL);
          lx_depth = '0;
          lx_mode = LX_IDLE;
        end else begin
          // depth saturates instead of wrapping
          if (c == CH_BQUOTE && lx_depth != {DEPTH_BITS{1'b1}}) lx_depth = lx_depth + 1'b1;
          if (c == CH_QUOTE) lx_depth = lx_depth - 1'b1;
          add_res(tlc_pkg::KIND_BYTE, c, tlc_pkg::CLS_SPECIAL);
          if (c == CH_QUOTE && lx_depth == '0) begin
            add_res(tlc_pkg::KIND_END, CH_NUL, tlc_pkg::CLS_QUOTED);
            lx_mode = LX_IDLE;
          end
        end
      end
      LX_EQ: begin
        if (fin) begin
          add_res(tlc_pkg::KIND_END, CH_NUL, tlc_pkg::CLS_SPECIAL);
          add_res(tlc_pkg::KIND_DONE, CH_NUL, tlc_pkg::CLS_SPECIAL);
          lx_mode = LX_IDLE;
        end else if (c == CH_BANG) begin
          add_res(tlc_pkg::KIND_BYTE, c, tlc_pkg::CLS_SPECIAL);
          add_res(tlc_pkg::KIND_END, CH_NUL, tlc_pkg::CLS_SPECIAL);
          lx_mode = LX_IDLE;
        end else begin
          add_res(tlc_pkg::KIND_END, CH_NUL, tlc_pkg::CLS_SPECIAL);
          idle_take(c);
        end
      end
      LX_WORD: begin
        if (fin) begin
          add_res(tlc_pkg::KIND_END, CH_NUL, word_cls());
          add_res(tlc_pkg::KIND_DONE, CH_NUL, tlc_pkg::CLS_SPECIAL);
          lx_mode = LX_IDLE;
        end else if (is_space(c)) begin
          add_res(tlc_pkg::KIND_END, CH_NUL, word_cls());
          lx_mode = LX_IDLE;
        end else if (is_special(c)) begin
          add_res(tlc_pkg::KIND_END, CH_NUL, word_cls());
          idle_take(c);
        end else begin
          word_take(c);
          add_res(tlc_pkg::KIND_BYTE, c, tlc_pkg::CLS_SPECIAL);
        end
      end
      default: begin
        lx_mode = LX_IDLE;
        if (fin) add_res(tlc_pkg::KIND_DONE, CH_NUL, tlc_pkg::CLS_SPECIAL);
        else idle_take(c);
      end
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) due_results.push_back(step_res[i]);
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  task automatic send_word(input logic [7:0] b, input logic e);
    int unsigned gap;
    gap = $urandom_range(send_gap_max, 0);
    // a lowered push is never raised again without a gap
    if (!push_up && gap == 0) gap = 1;
    if (gap > 0) begin
      if (push_up) push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    push_up = 1'b1;
    in_byte_i <= b;
    at_end_i <= e;
    do begin
      @(posedge clk_i);
      if (full) full_stalls++;
    end while (full);
    lex_predict(b, e);
    words_sent++;
  endtask

  task automatic send_ch(input logic [7:0] c);
    send_word(c, 1'b0);
  endtask

  task automatic drain();
    if (push_up) push <= 1'b0;
    push_up = 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_result();
    tok_res_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result kind %0d with nothing expected", kind_o));
    end else begin
      want = due_results.pop_front();
      results_checked++;
      if (want.kind == tlc_pkg::KIND_END) class_seen[want.cls]++;
      if (kind_o !== want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", kind_o, want.kind));
      if (out_byte_o !== want.data)
        report_mismatch($sformatf("out_byte %h, expected %h", out_byte_o, want.data));
      if (token_class_o !== want.cls)
        report_mismatch($sformatf("token_class %0d, expected %0d", token_class_o, want.cls));
      if (last_of_step_o !== want.last)
        report_mismatch($sformatf("last_of_step %0d, expected %0d", last_of_step_o, want.last));
    end
  endtask

  // receiver: random gaps plus an occasional long hold requested by a test
  initial begin
    int unsigned gap;
    wait (rst_ni);
    forever begin
      gap = $urandom_range(recv_gap_max, 0) + recv_hold;
      recv_hold = 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      check_result();
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, due_results.size());
      $display("tb_token_lexer_classifier_unit: done, errors");
      $finish;
    end
  end

  function automatic logic [7:0] pick_space();
    int unsigned r;
    r = $urandom_range(5, 0);
    return (r == 5) ? CH_SPACE : CH_TAB + r[7:0];
  endfunction

  function automatic logic [7:0] pick_word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(127, 0)); while (is_space(c) || is_special(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_hex_digit();
    int unsigned r;
    r = $urandom_range(15, 0);
    if (r < 10) return CH_ZERO + r[7:0];
    return ($urandom_range(1, 0) ? CH_UPPER_A : CH_LOWER_A) + r[7:0] - 8'd10;
  endfunction

  task automatic send_digits(input int unsigned lo, input int unsigned hi);
    int unsigned n;
    n = $urandom_range(hi, lo);
    repeat (n) send_ch(CH_ZERO + 8'($urandom_range(9, 0)));
  endtask

  task automatic send_end_word();
    if ($urandom_range(1, 0)) send_word(8'($urandom_range(255, 0)), 1'b1);
    else send_word(8'($urandom_range(255, 128)), 1'b0);
  endtask

  // quoted token with random nesting; sometimes cut off by end of input
  task automatic send_quoted();
    int unsigned depth;
    int unsigned n;
    logic [7:0]  c;
    depth = 1;
    send_ch(CH_BQUOTE);
    n = $urandom_range(6, 0);
    repeat (n) begin
      case ($urandom_range(3, 0))
        0: begin
          send_ch(CH_BQUOTE);
          depth++;
        end
        1: begin
          if (depth > 1) begin
            send_ch(CH_QUOTE);
            depth--;
          end
        end
        default: begin
          do c = 8'($urandom_range(127, 0)); while (c == CH_BQUOTE || c == CH_QUOTE);
          send_ch(c);
        end
      endcase
    end
    if ($urandom_range(7, 0) == 0) send_end_word();
    else repeat (depth) send_ch(CH_QUOTE);
  endtask

  task automatic send_lexeme();
    logic [7:0] c;
    case ($urandom_range(11, 0))
      0: send_ch(specials[$urandom_range(10, 0)]);
      1: begin
        send_ch(CH_EQ);
        if ($urandom_range(1, 0)) send_ch(CH_BANG);
      end
      2: begin
        if ($urandom_range(1, 0)) send_ch(CH_MINUS);
        send_digits(1, 4);
      end
      3: begin
        send_ch(CH_ZERO);
        send_ch($urandom_range(1, 0) ? CH_UPPER_X : CH_LOWER_X);
        repeat ($urandom_range(4, 0)) send_ch(pick_hex_digit());
      end
      4: begin
        if ($urandom_range(1, 0)) send_ch(CH_MINUS);
        send_digits(0, 2);
        if ($urandom_range(1, 0)) begin
          send_ch(CH_DOT);
          send_digits(0, 2);
        end
        if ($urandom_range(1, 0)) begin
          send_ch($urandom_range(1, 0) ? CH_UPPER_E : CH_LOWER_E);
          if ($urandom_range(1, 0)) send_ch(CH_MINUS);
          send_digits(0, 2);
        end
      end
      5: repeat ($urandom_range(5, 1)) send_ch(pick_word_char());
      6: send_quoted();
      7: begin
        send_ch(CH_PERCENT);
        repeat ($urandom_range(5, 0)) begin
          do c = 8'($urandom_range(127, 0)); while (c == CH_LF);
          send_ch(c);
        end
        if ($urandom_range(5, 0) == 0) send_end_word();
        else send_ch(CH_LF);
      end
      8: send_end_word();
      9: send_word(8'($urandom_range(255, 0)), $urandom_range(7, 0) == 0);
      default: repeat ($urandom_range(2, 1)) send_ch(pick_space());
    endcase
    // words glue together unless something separates them
    if ($urandom_range(1, 0)) send_ch(pick_space());
  endtask

  task automatic test_directed();
    send_gap_max = 3;
    recv_gap_max = 3;
    send_ch(CH_EQ);
    send_ch(CH_BANG);
    send_ch(CH_EQ);
    send_ch(CH_LBRACE);      // lone '=' closed by a special: three results
    send_ch(CH_ZERO);
    send_ch(CH_LOWER_X);
    send_ch(CH_UPPER_F);
    send_ch(CH_COMMA);
    send_ch(CH_MINUS);
    send_ch(CH_DOT);
    send_ch(CH_LOWER_E);
    send_ch(CH_NINE);
    send_word(CH_HIGH, 1'b0); // high byte ends input right after a word
    send_ch(CH_BQUOTE);
    send_ch(CH_BQUOTE);
    send_ch(CH_QUOTE);
    send_ch(CH_QUOTE);
    send_ch(CH_BQUOTE);
    send_word(CH_UPPER_A, 1'b1); // end inside a quote
    send_ch(CH_PERCENT);
    send_ch(CH_DEL);
    send_word(CH_HIGH, 1'b1);   // end inside a comment
    send_word(CH_NUL, 1'b1);    // end at idle
    send_ch(CH_EQ);
    send_word(CH_DEL, 1'b1);
    send_ch(CH_NUL);
    send_ch(CH_SPACE);
    drain();
  endtask

  task automatic test_backpressure();
    send_gap_max = 0;
    recv_gap_max = 0;
    recv_hold = 64;
    repeat (15) begin
      send_ch(CH_LOWER_A);
      send_ch(CH_LOWER_B);
      send_ch(CH_LPAREN);
    end
    drain();
  endtask

  task automatic test_random_stream();
    int unsigned start;
    int unsigned chunk_start;
    start = words_sent;
    chunk_start = words_sent;
    while (words_sent < start + RANDOM_WORDS) begin
      if (words_sent >= chunk_start + 40) begin
        chunk_start = words_sent;
        case ($urandom_range(3, 0))
          0: begin
            send_gap_max = 0;
            recv_gap_max = 0;
          end
          1: begin
            send_gap_max = 7;
            recv_gap_max = 0;
          end
          2: begin
            send_gap_max = 0;
            recv_gap_max = 7;
          end
          default: begin
            send_gap_max = 7;
            recv_gap_max = 7;
          end
        endcase
      end
      send_lexeme();
    end
    send_end_word();
    drain();
  endtask

  // one deeply nested quote closed a level at a time, then a word and end
  task automatic test_quote_nesting();
    send_gap_max = 0;
    recv_gap_max = 0;
    repeat (QUOTE_NEST) send_ch(CH_BQUOTE);
    repeat (QUOTE_NEST) send_ch(CH_QUOTE);
    send_ch(CH_NINE);
    send_word(CH_NUL, 1'b1);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_stream();
    test_quote_nesting();
    repeat (16) @(posedge clk_i);
    $display("covered %0d words in, %0d results checked, %0d cycles with input held off",
             words_sent, results_checked, full_stalls);
    $display("token ends: special %0d quoted %0d dec %0d hex %0d float %0d word %0d",
             class_seen[tlc_pkg::CLS_SPECIAL], class_seen[tlc_pkg::CLS_QUOTED],
             class_seen[tlc_pkg::CLS_DEC], class_seen[tlc_pkg::CLS_HEX],
             class_seen[tlc_pkg::CLS_FLOAT], class_seen[tlc_pkg::CLS_WORD]);
    if (error_count == 0) begin
      $display("tb_token_lexer_classifier_unit: done, clean");
    end else begin
      $display("tb_token_lexer_classifier_unit: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/tlc_pkg.sv
rtl/core/tlc_front.sv
rtl/core/tlc_queue.sv
rtl/core/tlc_back.sv
rtl/core/token_lexer_classifier_unit.sv
bench/tb_token_lexer_classifier_unit.sv
